[hdl/rgct_pkg.sv]
package rgct_pkg;

  localparam int GridX = 16;
  localparam int GridY = 16;
  localparam int GridZ = 16;
  localparam int GridMax = (GridX > GridY) ? ((GridX > GridZ) ? GridX : GridZ)
                                           : ((GridY > GridZ) ? GridY : GridZ);
  localparam int CellW = (GridMax > 1) ? $clog2(GridMax) : 1;
  localparam int GridNW = $clog2(GridMax + 1);
  localparam int IdxW = 12;
  localparam int MaxResults = 46;
  localparam int CntW = $clog2(MaxResults + 1);

  localparam int NumW = 56;
  localparam int DenW = 33;
  localparam int DivSteps = 2;
  localparam int DivCycles = NumW / DivSteps;
  localparam int DivCntW = $clog2(DivCycles);

  localparam int FifoDepth = 2;
  localparam int FifoAw = $clog2(FifoDepth);

  localparam logic [2:0] CfgGridMinX  = 3'd0;
  localparam logic [2:0] CfgGridMinY  = 3'd1;
  localparam logic [2:0] CfgGridMinZ  = 3'd2;
  localparam logic [2:0] CfgCellSizeX = 3'd3;
  localparam logic [2:0] CfgCellSizeY = 3'd4;
  localparam logic [2:0] CfgCellSizeZ = 3'd5;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  localparam logic signed [NumW-1:0] SatHi = NumW'(2147483647);
  localparam logic signed [NumW-1:0] SatLo = -SatHi - NumW'(1);

  typedef struct packed {
    logic signed [31:0] ray_origin_x;
    logic signed [31:0] ray_origin_y;
    logic signed [31:0] ray_origin_z;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] ray_dir_z;
    logic signed [31:0] t_lower;
    logic signed [31:0] t_upper;
  } ray_t;

  typedef struct packed {
    logic               cell_valid;
    logic [IdxW-1:0]    cell_index;
    logic signed [31:0] t_entry;
    logic               last_cell;
  } cell_t;

  typedef struct packed {
    logic [2:0][31:0] grid_min;
    logic [2:0][30:0] cell_size;
  } cfg_t;

  typedef struct packed {
    logic                  miss;
    logic [2:0][31:0]      org;
    logic [2:0][31:0]      dir;
    logic [2:0][CellW-1:0] start_cell;
    logic [31:0]           t_min;
    logic [31:0]           t_max;
  } job_t;

  function automatic logic [GridNW-1:0] grid_n(input logic [1:0] a);
    logic [GridNW-1:0] n;
    case (a)
      AxisX:   n = GridNW'(GridX);
      AxisY:   n = GridNW'(GridY);
      default: n = GridNW'(GridZ);
    endcase
    return n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [NumW-1:0] v);
    logic signed [NumW-1:0] r;
    if (v > SatHi) r = SatHi;
    else if (v < SatLo) r = SatLo;
    else r = v;
    return r[31:0];
  endfunction

endpackage

[hdl/ray_grid_cell_traversal.sv]
// ray walker over a uniform 3d grid
// input channel (in_valid_i/in_ready_o/in_data_i): one ray per transfer,
// origin, direction and t range in signed q16.16
// output channel (out_valid_o/out_ready_i/out_data_o): one transfer per
// visited cell in walk order, last_cell set on the final one; a ray that
// misses the grid box gives a single transfer with cell_valid low
// config port (cfg_we_i/cfg_idx_i/cfg_data_i): grid corner and cell sizes,
// written while the block is idle
// the front end clips a ray per axis with a nonzero direction, then, for
// a hit, finds the start cell per axis, all on its own 2-bit-per-cycle
// divider; a 2-entry job queue lets the front end take the next ray
// while the walker runs
// the walker sets up a ray, then takes one step per visited cell, using its
// own divider producing one crossing time per step
// a stalled output holds its result and the walker waits; the front end and
// the queue keep going until the queue is full
// reset clears the config to a zero corner and unit cells, empties the
// queue and drops out_valid_o
module ray_grid_cell_traversal import rgct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ray_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cell_t       out_data_o
);

  cfg_t cfg_q;
  logic job_push, job_full, job_pop, job_empty;
  job_t job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_min  <= '0;
      cfg_q.cell_size <= {3{31'd65536}};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGridMinX: cfg_q.grid_min[AxisX] <= cfg_data_i;
        CfgGridMinY: cfg_q.grid_min[AxisY] <= cfg_data_i;
        CfgGridMinZ: cfg_q.grid_min[AxisZ] <= cfg_data_i;
        CfgCellSizeX: cfg_q.cell_size[AxisX] <= (cfg_data_i[30:0] == '0) ? 31'd1
                                                                         : cfg_data_i[30:0];
        CfgCellSizeY: cfg_q.cell_size[AxisY] <= (cfg_data_i[30:0] == '0) ? 31'd1
                                                                         : cfg_data_i[30:0];
        CfgCellSizeZ: cfg_q.cell_size[AxisZ] <= (cfg_data_i[30:0] == '0) ? 31'd1
                                                                         : cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  rgct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  rgct_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  rgct_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hdl/rgct_div.sv]
module rgct_div import rgct_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic signed [DenW-1:0] den_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic signed [NumW-1:0] quo_o
);

  logic                busy_q, done_q, neg_q;
  logic [DivCntW-1:0]  cnt_q;
  logic [NumW-1:0]     shr_q, shr_d;
  logic [DenW-2:0]     rem_q, rem_d, dmag_q;
  logic signed [NumW-1:0] quo_q;
  logic [NumW-1:0]     nmag;
  logic [DenW-1:0]     dmag_full;

  always_comb begin
    nmag      = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
    dmag_full = den_i[DenW-1] ? DenW'(-den_i) : DenW'(den_i);
  end

  // restoring division, DivSteps quotient bits per cycle
  always_comb begin : step
    logic [DenW-1:0] r2;
    rem_d = rem_q;
    shr_d = shr_q;
    for (int i = 0; i < DivSteps; i++) begin
      r2 = {rem_d, shr_d[NumW-1]};
      shr_d = {shr_d[NumW-2:0], 1'b0};
      if (r2 >= {1'b0, dmag_q}) begin
        r2 = r2 - {1'b0, dmag_q};
        shr_d[0] = 1'b1;
      end
      rem_d = r2[DenW-2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivCycles - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      shr_q  <= nmag;
      rem_q  <= '0;
      dmag_q <= dmag_full[DenW-2:0];
      neg_q  <= num_i[NumW-1] ^ den_i[DenW-1];
    end else if (busy_q) begin
      shr_q <= shr_d;
      rem_q <= rem_d;
      if (cnt_q == DivCntW'(DivCycles - 1)) begin
        quo_q <= neg_q ? -$signed(shr_d) : $signed(shr_d);
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[hdl/rgct_front.sv]
module rgct_front import rgct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  ray_t in_data_i,
  output logic job_push_o,
  output job_t job_o,
  input  logic job_full_i
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StSlab  = 4'd1;
  localparam logic [3:0] StSlo   = 4'd2;
  localparam logic [3:0] StShi   = 4'd3;
  localparam logic [3:0] StCheck = 4'd4;
  localparam logic [3:0] StMul   = 4'd5;
  localparam logic [3:0] StEdiv  = 4'd6;
  localparam logic [3:0] StEwait = 4'd7;
  localparam logic [3:0] StPush  = 4'd8;

  logic [3:0]             state_q;
  logic [1:0]             axis_q;
  ray_t                   ray_q;
  logic signed [NumW-1:0] tmin_q, tmax_q, t0_q;
  logic                   hit_q, miss_q;
  logic [2:0][CellW-1:0]  cell_q;
  logic signed [63:0]     prod_q;

  logic signed [31:0]     o_sel, d_sel;
  logic signed [63:0]     lo, hi, o64, lo_num, hi_num, prod_tr, ent_num;
  logic signed [NumW-1:0] div_num, quo, lo_t, hi_t;
  logic signed [DenW-1:0] div_den;
  logic                   div_start, div_busy, div_done;

  always_comb begin
    unique case (axis_q)
      AxisX: begin
        o_sel = ray_q.ray_origin_x;
        d_sel = ray_q.ray_dir_x;
      end
      AxisY: begin
        o_sel = ray_q.ray_origin_y;
        d_sel = ray_q.ray_dir_y;
      end
      default: begin
        o_sel = ray_q.ray_origin_z;
        d_sel = ray_q.ray_dir_z;
      end
    endcase
  end

  always_comb begin
    o64     = 64'(o_sel);
    lo      = 64'($signed(cfg_i.grid_min[axis_q]));
    hi      = lo + $signed(64'(grid_n(axis_q)) * 64'(cfg_i.cell_size[axis_q]));
    lo_num  = (lo - o64) <<< 16;
    hi_num  = (hi - o64) <<< 16;
    prod_tr = prod_q[63] ? ((prod_q + 64'sd65535) >>> 16) : (prod_q >>> 16);
    ent_num = o64 + prod_tr - lo;
    lo_t    = d_sel[31] ? quo : t0_q;
    hi_t    = d_sel[31] ? t0_q : quo;
  end

  always_comb begin
    div_num   = ent_num[NumW-1:0];
    div_den   = $signed({2'b00, cfg_i.cell_size[axis_q]});
    div_start = 1'b0;
    case (state_q)
      StSlab: begin
        div_num   = lo_num[NumW-1:0];
        div_den   = DenW'(d_sel);
        div_start = (d_sel != '0);
      end
      StSlo: begin
        div_num   = hi_num[NumW-1:0];
        div_den   = DenW'(d_sel);
        div_start = div_done;
      end
      StEdiv: div_start = 1'b1;
      default: ;
    endcase
  end

  rgct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      axis_q  <= AxisX;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StSlab;
            axis_q  <= AxisX;
          end
        end
        StSlab: begin
          if (d_sel == '0) begin
            if (axis_q == AxisZ) state_q <= StCheck;
            else axis_q <= axis_q + 2'd1;
          end else if (!div_busy) begin
            state_q <= StSlo;
          end
        end
        StSlo: if (div_done) state_q <= StShi;
        StShi: begin
          if (div_done) begin
            if (axis_q == AxisZ) state_q <= StCheck;
            else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= StSlab;
            end
          end
        end
        StCheck: begin
          axis_q <= AxisX;
          if (!hit_q || tmin_q > tmax_q) state_q <= StPush;
          else state_q <= StMul;
        end
        StMul:  state_q <= StEdiv;
        StEdiv: state_q <= StEwait;
        StEwait: begin
          if (div_done) begin
            if (axis_q == AxisZ) state_q <= StPush;
            else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= StMul;
            end
          end
        end
        StPush: if (!job_full_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ray_q  <= in_data_i;
          tmin_q <= NumW'(in_data_i.t_lower);
          tmax_q <= NumW'(in_data_i.t_upper);
          hit_q  <= 1'b1;
        end
      end
      StSlab: begin
        if (d_sel == '0 && (o64 < lo || o64 > hi)) hit_q <= 1'b0;
      end
      StSlo: if (div_done) t0_q <= quo;
      StShi: begin
        if (div_done) begin
          if (lo_t > tmin_q) tmin_q <= lo_t;
          if (hi_t < tmax_q) tmax_q <= hi_t;
        end
      end
      StCheck: miss_q <= !hit_q || tmin_q > tmax_q;
      StMul: prod_q <= 64'(d_sel) * 64'($signed(tmin_q[31:0]));
      StEwait: begin
        if (div_done) begin
          if (quo < 0) cell_q[axis_q] <= '0;
          else if (quo > NumW'(grid_n(axis_q)) - NumW'(1))
            cell_q[axis_q] <= CellW'(grid_n(axis_q) - GridNW'(1));
          else cell_q[axis_q] <= quo[CellW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);
  assign job_push_o = (state_q == StPush) && !job_full_i;

  always_comb begin
    job_o.miss       = miss_q;
    job_o.org        = {ray_q.ray_origin_z, ray_q.ray_origin_y, ray_q.ray_origin_x};
    job_o.dir        = {ray_q.ray_dir_z, ray_q.ray_dir_y, ray_q.ray_dir_x};
    job_o.start_cell = cell_q;
    job_o.t_min      = tmin_q[31:0];
    job_o.t_max      = tmax_q[31:0];
  end

endmodule

[hdl/rgct_fifo.sv]
module rgct_fifo import rgct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  job_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_q, rd_q;
  logic [FifoAw:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + FifoAw'(1);
      if (pop_i) rd_q <= rd_q + FifoAw'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + (FifoAw+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (FifoAw+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);

endmodule

[hdl/rgct_walk.sv]
module rgct_walk import rgct_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  job_empty_i,
  input  job_t  job_i,
  output logic  job_pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output cell_t out_data_o
);

  localparam logic [1:0] WIdle = 2'd0;
  localparam logic [1:0] WAxis = 2'd1;
  localparam logic [1:0] WWait = 2'd2;
  localparam logic [1:0] WDec  = 2'd3;

  logic [1:0]             state_q;
  job_t                   job_q;
  logic [2:0][CellW-1:0]  cell_q;
  logic signed [NumW-1:0] t_q;
  logic [2:0][NumW-1:0]   tc_q;
  logic [2:0]             inf_q;
  logic [1:0]             axis_q;
  logic                   init_q;
  logic [CntW-1:0]        cnt_q;
  logic                   out_valid_q;
  cell_t                  out_q;

  logic signed [31:0]     d_a;
  logic signed [63:0]     o64, plane, num64;
  logic                   div_start, div_busy, div_done;
  logic signed [NumW-1:0] quo;
  logic                   lt01, lt02, lt12;
  logic [1:0]             ax;
  logic                   pos_ax, at_edge, late, dec_last, out_free, out_load;
  logic [IdxW-1:0]        cur_idx;

  function automatic logic lt(input logic ia, input logic ib,
                              input logic [NumW-1:0] a, input logic [NumW-1:0] b);
    return !ia && (ib || ($signed(a) < $signed(b)));
  endfunction

  always_comb begin
    d_a   = $signed(job_q.dir[axis_q]);
    o64   = 64'($signed(job_q.org[axis_q]));
    plane = $signed(64'(GridNW'(cell_q[axis_q]) + GridNW'(!d_a[31]))
                    * 64'(cfg_i.cell_size[axis_q]))
            + 64'($signed(cfg_i.grid_min[axis_q]));
    num64 = (plane - o64) <<< 16;
  end

  assign div_start = (state_q == WAxis) && (d_a != '0);

  rgct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num64[NumW-1:0]),
    .den_i   (DenW'(d_a)),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    lt01 = lt(inf_q[0], inf_q[1], tc_q[0], tc_q[1]);
    lt02 = lt(inf_q[0], inf_q[2], tc_q[0], tc_q[2]);
    lt12 = lt(inf_q[1], inf_q[2], tc_q[1], tc_q[2]);
    if (lt01 && lt02) ax = AxisX;
    else if (lt12) ax = AxisY;
    else ax = AxisZ;
    pos_ax  = !job_q.dir[ax][31];
    at_edge = pos_ax ? ((GridNW'(cell_q[ax]) + GridNW'(1)) == grid_n(ax))
                     : (cell_q[ax] == '0);
    late    = $signed(tc_q[ax]) > NumW'($signed(job_q.t_max));
    dec_last = (cnt_q == CntW'(MaxResults)) || inf_q[ax] || at_edge || late;
    cur_idx = IdxW'(cell_q[0])
            + IdxW'(GridX) * (IdxW'(cell_q[1]) + IdxW'(GridY) * IdxW'(cell_q[2]));
    out_free = !out_valid_q || out_ready_i;
  end

  assign job_pop_o = (state_q == WIdle) && !job_empty_i && (!job_i.miss || out_free);
  assign out_load  = (job_pop_o && job_i.miss) || ((state_q == WDec) && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= WIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      axis_q      <= AxisX;
      init_q      <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        WIdle: begin
          if (job_pop_o && !job_i.miss) begin
            state_q <= WAxis;
            axis_q  <= AxisX;
            init_q  <= 1'b1;
            cnt_q   <= CntW'(1);
          end
        end
        WAxis: begin
          if (d_a == '0) begin
            if (init_q && axis_q != AxisZ) axis_q <= axis_q + 2'd1;
            else state_q <= WDec;
          end else if (!div_busy) begin
            state_q <= WWait;
          end
        end
        WWait: begin
          if (div_done) begin
            if (init_q && axis_q != AxisZ) begin
              axis_q  <= axis_q + 2'd1;
              state_q <= WAxis;
            end else state_q <= WDec;
          end
        end
        WDec: begin
          if (out_free) begin
            if (dec_last) state_q <= WIdle;
            else begin
              state_q <= WAxis;
              axis_q  <= ax;
              init_q  <= 1'b0;
              cnt_q   <= cnt_q + CntW'(1);
            end
          end
        end
        default: state_q <= WIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q  <= job_i;
      cell_q <= job_i.start_cell;
      t_q    <= NumW'($signed(job_i.t_min));
    end
    if (state_q == WAxis && d_a == '0) inf_q[axis_q] <= 1'b1;
    if (state_q == WWait && div_done) begin
      inf_q[axis_q] <= 1'b0;
      tc_q[axis_q]  <= quo;
    end
    if (state_q == WDec && out_free && !dec_last) begin
      cell_q[ax] <= pos_ax ? cell_q[ax] + CellW'(1) : cell_q[ax] - CellW'(1);
      t_q        <= $signed(tc_q[ax]);
    end
    if (out_load) begin
      if (state_q == WDec) begin
        out_q.cell_valid <= 1'b1;
        out_q.cell_index <= cur_idx;
        out_q.t_entry    <= sat32(t_q);
        out_q.last_cell  <= dec_last;
      end else begin
        out_q.cell_valid <= 1'b0;
        out_q.cell_index <= '0;
        out_q.t_entry    <= '0;
        out_q.last_cell  <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_miss_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.cell_valid) |-> out_q.last_cell)
    else $error("miss result without last_cell");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxResults))
    else $error("result count beyond limit");

  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == WDec && out_free && dec_last) |=> (state_q == WIdle))
    else $error("walk continues after last cell");

endmodule
